// ----- hw/rtl/estm_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Euler transform builder.
`timescale 1ns / 1ps
package estm_pkg;

  localparam int DEFAULT_FRAC_BITS       = 16;
  localparam int DEFAULT_TRIG_ITERATIONS = 16;
  localparam int ANG_MAX_STEPS           = 24;

  localparam int WORD_W = 32;  // width of every Q16.16 field
  localparam int ANG_W  = 18;  // Q3.14 angle
  localparam int ZW     = 35;  // Q30 angle before folding
  localparam int TRIG_W = 34;  // Q30 sine, cosine, residual and rotation entries
  localparam int REM_W  = 33;  // divider partial remainder
  localparam int PW     = 36;  // rotation entry times factor, after rounding

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_STEPS [0:ANG_MAX_STEPS-1] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F};

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFFFFFF;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [TRIG_W-1:0] tval_t;

  typedef struct packed {
    tval_t x;
    tval_t y;
    tval_t z;
  } trig_t;

  // sideband carried alongside the iterative stages
  typedef struct packed {
    logic              op;
    logic [2:0]        flip;
    word_t [2:0]       scale;
    word_t [2:0]       pos;
    logic [2:0][31:0]  mag;
  } side_t;

  // Q30 x Q30 product, rounded half up to Q30
  function automatic tval_t mul_q30(input tval_t a, input tval_t b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b + $signed((2*TRIG_W)'(64'd1 << 29));
    mul_q30 = TRIG_W'(p >>> 30);
  endfunction

  // Q30 rotation entry times a Q(FRAC) factor, rounded to Q(FRAC)
  function automatic logic signed [PW-1:0] mul_fac(input tval_t a, input word_t b);
    logic signed [TRIG_W+WORD_W-1:0] p;
    p = a * b + $signed((TRIG_W+WORD_W)'(64'd1 << 29));
    mul_fac = PW'(p >>> 30);
  endfunction

  function automatic word_t sat_word(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = PW'(WORD_MAX);
    lo = PW'(WORD_MIN);
    if (v > hi) sat_word = WORD_MAX;
    else if (v < lo) sat_word = WORD_MIN;
    else sat_word = WORD_W'(v);
  endfunction

endpackage

// ----- hw/rtl/estm_iter_stage.sv -----
// One pipeline stage: a CORDIC rotation step per angle and a restoring divide step per scale.
`timescale 1ns / 1ps
module estm_iter_stage #(
  parameter int IDX             = 0,
  parameter int TRIG_ITERATIONS = estm_pkg::DEFAULT_TRIG_ITERATIONS,
  parameter int NUM_W           = 33
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 vld_i,
  input  estm_pkg::side_t                      side_i,
  input  estm_pkg::trig_t [2:0]                trig_i,
  input  logic [2:0][estm_pkg::REM_W-1:0]      rem_i,
  input  logic [2:0][NUM_W-1:0]                num_i,
  output logic                                 vld_o,
  output estm_pkg::side_t                      side_o,
  output estm_pkg::trig_t [2:0]                trig_o,
  output logic [2:0][estm_pkg::REM_W-1:0]      rem_o,
  output logic [2:0][NUM_W-1:0]                num_o
);
  import estm_pkg::*;

  logic                    vld_r;
  side_t                   side_r;
  trig_t [2:0]             trig_r, trig_nxt;
  logic [2:0][REM_W-1:0]   rem_r, rem_nxt;
  logic [2:0][NUM_W-1:0]   num_r, num_nxt;

  generate
    if (IDX < TRIG_ITERATIONS) begin : g_rot
      localparam tval_t ATAN_I = $signed(TRIG_W'(ATAN_STEPS[IDX]));
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          if (!trig_i[k].z[TRIG_W-1]) begin
            trig_nxt[k].x = trig_i[k].x - (trig_i[k].y >>> IDX);
            trig_nxt[k].y = trig_i[k].y + (trig_i[k].x >>> IDX);
            trig_nxt[k].z = trig_i[k].z - ATAN_I;
          end else begin
            trig_nxt[k].x = trig_i[k].x + (trig_i[k].y >>> IDX);
            trig_nxt[k].y = trig_i[k].y - (trig_i[k].x >>> IDX);
            trig_nxt[k].z = trig_i[k].z + ATAN_I;
          end
        end
      end
    end else begin : g_rot_pass
      assign trig_nxt = trig_i;
    end

    if (IDX < NUM_W) begin : g_div
      always_comb begin
        logic [REM_W-1:0] sh;
        logic             ge;
        for (int k = 0; k < 3; k++) begin
          sh = {rem_i[k][REM_W-2:0], num_i[k][NUM_W-1]};
          ge = (sh >= {1'b0, side_i.mag[k]});
          rem_nxt[k] = ge ? sh - {1'b0, side_i.mag[k]} : sh;
          num_nxt[k] = {num_i[k][NUM_W-2:0], ge};
        end
      end
    end else begin : g_div_pass
      assign rem_nxt = rem_i;
      assign num_nxt = num_i;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (en) vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      trig_r <= trig_nxt;
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign trig_o = trig_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;

endmodule

// ----- hw/rtl/euler_scale_translate_matrix.sv -----
// Top level: Y-X-Z rotation, scale and translation matrix builder, four column words per item.
// From acceptance to column 0 an item passes stage A, the per-stage CORDIC and reciprocal
//   divide steps, stages C to G and the output register, which sends one column word
//   per cycle while out_stall is low; every stage holds while it still has words to send.
// Reset (rst_n low, synchronous) empties every stage and the output register; no clearing pass.
`timescale 1ns / 1ps
module euler_scale_translate_matrix #(
  parameter int FRAC_BITS       = estm_pkg::DEFAULT_FRAC_BITS,
  parameter int TRIG_ITERATIONS = estm_pkg::DEFAULT_TRIG_ITERATIONS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic signed [17:0]   in_angle_x,
  input  logic signed [17:0]   in_angle_y,
  input  logic signed [17:0]   in_angle_z,
  input  logic signed [31:0]   in_scale_x,
  input  logic signed [31:0]   in_scale_y,
  input  logic signed [31:0]   in_scale_z,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_column_index,
  output logic signed [31:0]   out_elem_row0,
  output logic signed [31:0]   out_elem_row1,
  output logic signed [31:0]   out_elem_row2,
  output logic signed [31:0]   out_elem_row3,
  output logic                 out_zero_scale,
  output logic                 out_last_column
);
  import estm_pkg::*;

  localparam int NW   = ((2*FRAC_BITS > 31) ? 2*FRAC_BITS : 31) + 1;
  localparam int ITER = (TRIG_ITERATIONS > NW) ? TRIG_ITERATIONS : NW;
  localparam word_t ONE_VAL = WORD_W'(64'd1 << FRAC_BITS);
  localparam logic [1:0] LAST_COL = 2'd3;

  logic adv;

  // ---- stage A: angle to Q30 and wrap into [-pi, pi]
  logic                  a_vld_r;
  logic signed [ZW-1:0]  a_z_r [3];
  logic signed [ZW-1:0]  a_z_nxt [3];
  logic                  a_op_r;
  word_t [2:0]           a_scale_r;
  word_t [2:0]           a_pos_r;
  logic signed [ANG_W-1:0] ang [3];

  assign ang[0] = in_angle_y;
  assign ang[1] = in_angle_x;
  assign ang[2] = in_angle_z;

  always_comb begin
    logic signed [ZW-1:0] z;
    for (int k = 0; k < 3; k++) begin
      z = {ang[k][ANG_W-1], ang[k], 16'h0000};
      if (z > PI_Q30) a_z_nxt[k] = z - TWO_PI_Q30;
      else if (z < -PI_Q30) a_z_nxt[k] = z + TWO_PI_Q30;
      else a_z_nxt[k] = z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_z_r     <= a_z_nxt;
      a_op_r    <= in_operation;
      a_scale_r <= {in_scale_z, in_scale_y, in_scale_x};
      a_pos_r   <= {in_pos_z, in_pos_y, in_pos_x};
    end
  end

  // ---- fold into [-pi/2, pi/2], seed CORDIC and divider
  logic                   vld_s  [0:ITER];
  side_t                  side_s [0:ITER];
  trig_t [2:0]            trig_s [0:ITER];
  logic [2:0][REM_W-1:0]  rem_s  [0:ITER];
  logic [2:0][NW-1:0]     num_s  [0:ITER];

  always_comb begin
    logic signed [ZW-1:0] zf;
    vld_s[0]        = a_vld_r;
    side_s[0].op    = a_op_r;
    side_s[0].scale = a_scale_r;
    side_s[0].pos   = a_pos_r;
    for (int k = 0; k < 3; k++) begin
      if (a_z_r[k] > HALF_PI_Q30) begin
        zf = a_z_r[k] - PI_Q30;
        side_s[0].flip[k] = 1'b1;
      end else if (a_z_r[k] < -HALF_PI_Q30) begin
        zf = a_z_r[k] + PI_Q30;
        side_s[0].flip[k] = 1'b1;
      end else begin
        zf = a_z_r[k];
        side_s[0].flip[k] = 1'b0;
      end
      trig_s[0][k].x = CORDIC_GAIN;
      trig_s[0][k].y = '0;
      trig_s[0][k].z = TRIG_W'(zf);
      side_s[0].mag[k] = a_scale_r[k][WORD_W-1] ? 32'(-a_scale_r[k]) : 32'(a_scale_r[k]);
      rem_s[0][k] = '0;
      num_s[0][k] = NW'(64'd1 << (2*FRAC_BITS)) + NW'(side_s[0].mag[k] >> 1);
    end
  end

  generate
    for (genvar i = 0; i < ITER; i++) begin : g_stage
      estm_iter_stage #(
        .IDX             (i),
        .TRIG_ITERATIONS (TRIG_ITERATIONS),
        .NUM_W           (NW)
      ) u_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .vld_i  (vld_s[i]),
        .side_i (side_s[i]),
        .trig_i (trig_s[i]),
        .rem_i  (rem_s[i]),
        .num_i  (num_s[i]),
        .vld_o  (vld_s[i+1]),
        .side_o (side_s[i+1]),
        .trig_o (trig_s[i+1]),
        .rem_o  (rem_s[i+1]),
        .num_o  (num_s[i+1])
      );
    end
  endgenerate

  // ---- stage C: sign fix of sine/cosine, reciprocal sign and saturation, and factor select
  logic          c_vld_r;
  tval_t [2:0]   c_s_r, c_c_r, c_s_nxt, c_c_nxt;
  word_t [2:0]   c_fac_r, c_fac_nxt;
  logic          c_zero_r, c_zero_nxt;
  logic          c_op_r;
  word_t [2:0]   c_pos_r;

  always_comb begin
    side_t       sd;
    logic [NW-1:0] q;
    word_t       rc;
    sd = side_s[ITER];
    c_zero_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      c_s_nxt[k] = sd.flip[k] ? -trig_s[ITER][k].y : trig_s[ITER][k].y;
      c_c_nxt[k] = sd.flip[k] ? -trig_s[ITER][k].x : trig_s[ITER][k].x;
      q = num_s[ITER][k];
      if (sd.scale[k] == '0) begin
        rc = WORD_MAX;
        if (sd.op) c_zero_nxt = 1'b1;
      end else if (!sd.scale[k][WORD_W-1]) begin
        rc = (q > NW'(32'h7FFFFFFF)) ? WORD_MAX : word_t'(q[WORD_W-1:0]);
      end else begin
        rc = (q > NW'(32'h80000000)) ? WORD_MIN : -word_t'(q[WORD_W-1:0]);
      end
      c_fac_nxt[k] = sd.op ? rc : sd.scale[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (adv) c_vld_r <= vld_s[ITER];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_s_r    <= c_s_nxt;
      c_c_r    <= c_c_nxt;
      c_fac_r  <= c_fac_nxt;
      c_zero_r <= c_zero_nxt;
      c_op_r   <= side_s[ITER].op;
      c_pos_r  <= side_s[ITER].pos;
    end
  end

  // ---- stage D: s1*s2 and c1*s2
  logic          d_vld_r;
  tval_t [2:0]   d_s_r, d_c_r;
  tval_t         d_s1s2_r, d_c1s2_r;
  word_t [2:0]   d_fac_r;
  logic          d_zero_r, d_op_r;
  word_t [2:0]   d_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (adv) d_vld_r <= c_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_s1s2_r <= mul_q30(c_s_r[0], c_s_r[1]);
      d_c1s2_r <= mul_q30(c_c_r[0], c_s_r[1]);
      d_s_r    <= c_s_r;
      d_c_r    <= c_c_r;
      d_fac_r  <= c_fac_r;
      d_zero_r <= c_zero_r;
      d_op_r   <= c_op_r;
      d_pos_r  <= c_pos_r;
    end
  end

  // ---- stage E: the twelve products feeding the rotation entries
  logic          e_vld_r;
  tval_t [11:0]  e_p_r;
  tval_t         e_s2_r;
  word_t [2:0]   e_fac_r;
  logic          e_zero_r, e_op_r;
  word_t [2:0]   e_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else if (adv) e_vld_r <= d_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_p_r[0]  <= mul_q30(d_c_r[0], d_c_r[2]);
      e_p_r[1]  <= mul_q30(d_s1s2_r, d_s_r[2]);
      e_p_r[2]  <= mul_q30(d_c_r[1], d_s_r[2]);
      e_p_r[3]  <= mul_q30(d_c1s2_r, d_s_r[2]);
      e_p_r[4]  <= mul_q30(d_s_r[0], d_c_r[2]);
      e_p_r[5]  <= mul_q30(d_s1s2_r, d_c_r[2]);
      e_p_r[6]  <= mul_q30(d_s_r[2], d_c_r[0]);
      e_p_r[7]  <= mul_q30(d_c_r[1], d_c_r[2]);
      e_p_r[8]  <= mul_q30(d_s_r[0], d_s_r[2]);
      e_p_r[9]  <= mul_q30(d_c1s2_r, d_c_r[2]);
      e_p_r[10] <= mul_q30(d_s_r[0], d_c_r[1]);
      e_p_r[11] <= mul_q30(d_c_r[0], d_c_r[1]);
      e_s2_r    <= d_s_r[1];
      e_fac_r   <= d_fac_r;
      e_zero_r  <= d_zero_r;
      e_op_r    <= d_op_r;
      e_pos_r   <= d_pos_r;
    end
  end

  // ---- stage F: rotation entries, flat index column*3 + row
  logic          f_vld_r;
  tval_t [8:0]   f_rot_r;
  word_t [2:0]   f_fac_r;
  logic          f_zero_r, f_op_r;
  word_t [2:0]   f_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (adv) f_vld_r <= e_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_rot_r[0] <= e_p_r[0] + e_p_r[1];
      f_rot_r[1] <= e_p_r[2];
      f_rot_r[2] <= e_p_r[3] - e_p_r[4];
      f_rot_r[3] <= e_p_r[5] - e_p_r[6];
      f_rot_r[4] <= e_p_r[7];
      f_rot_r[5] <= e_p_r[8] + e_p_r[9];
      f_rot_r[6] <= e_p_r[10];
      f_rot_r[7] <= -e_s2_r;
      f_rot_r[8] <= e_p_r[11];
      f_fac_r    <= e_fac_r;
      f_zero_r   <= e_zero_r;
      f_op_r     <= e_op_r;
      f_pos_r    <= e_pos_r;
    end
  end

  // ---- stage G: entry times column factor
  logic                      g_vld_r;
  logic signed [PW-1:0]      g_m_r [9];
  logic                      g_zero_r, g_op_r;
  word_t [2:0]               g_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else if (adv) g_vld_r <= f_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 9; n++) g_m_r[n] <= mul_fac(f_rot_r[n], f_fac_r[n/3]);
      g_zero_r <= f_zero_r;
      g_op_r   <= f_op_r;
      g_pos_r  <= f_pos_r;
    end
  end

  // ---- output register: holds one item, sends a column word per cycle while out_stall is low
  logic          ser_vld_r;
  logic [1:0]    col_r;
  word_t [8:0]   ser_m_r;
  word_t [2:0]   ser_pos_r;
  logic          ser_op_r, ser_zero_r;
  logic          out_fire, ser_done;

  assign out_fire = ser_vld_r && !out_stall;
  assign ser_done = out_fire && (col_r == LAST_COL);
  assign adv      = !ser_vld_r || ser_done;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      col_r     <= '0;
    end else if (adv) begin
      ser_vld_r <= g_vld_r;
      col_r     <= '0;
    end else if (out_fire) begin
      col_r <= col_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 9; n++) ser_m_r[n] <= sat_word(g_m_r[n]);
      ser_pos_r  <= g_pos_r;
      ser_op_r   <= g_op_r;
      ser_zero_r <= g_zero_r;
    end
  end

  always_comb begin
    word_t r0, r1, r2;
    if (col_r == LAST_COL) begin
      r0 = ser_op_r ? '0 : ser_pos_r[0];
      r1 = ser_op_r ? '0 : ser_pos_r[1];
      r2 = ser_op_r ? '0 : ser_pos_r[2];
    end else begin
      r0 = ser_m_r[{2'b00, col_r} * 4'd3];
      r1 = ser_m_r[{2'b00, col_r} * 4'd3 + 4'd1];
      r2 = ser_m_r[{2'b00, col_r} * 4'd3 + 4'd2];
    end
    out_elem_row0 = r0;
    out_elem_row1 = r1;
    out_elem_row2 = r2;
  end

  assign out_valid        = ser_vld_r;
  assign out_column_index = col_r;
  assign out_elem_row3    = (col_r == LAST_COL) ? ONE_VAL : '0;
  assign out_zero_scale   = ser_zero_r;
  assign out_last_column  = (col_r == LAST_COL);

endmodule

// ----- tb/sv/euler_scale_translate_matrix_test.sv -----
// Testbench for the Y-X-Z rotation, scale and translation matrix builder.
`timescale 1ns / 1ps
module euler_scale_translate_matrix_test;
  import estm_pkg::*;

  localparam int FRAC = DEFAULT_FRAC_BITS;
  localparam int ITERS = DEFAULT_TRIG_ITERATIONS;
  localparam int LATENCY = 40;
  localparam logic OP_MODEL = 1'b0;
  localparam logic OP_NORMAL = 1'b1;

  typedef struct {
    logic op;
    logic signed [17:0] ax, ay, az;
    logic signed [31:0] sc [3];
    logic signed [31:0] ps [3];
  } xform_t;

  typedef struct {
    logic [1:0] idx;
    logic signed [31:0] e [4];
    logic zs;
    logic last;
  } column_t;

  // matrix column words predicted from accepted items, checked in order
  class column_board;
    column_t pending[$];
    int errors;

    function longint rnd30(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void sincos(logic signed [17:0] a, output longint sn, output longint cs);
      longint z, x, y, t;
      longint pi;
      bit flip;
      pi = 64'sd3373259426;
      z = longint'(a) * 65536;
      x = 652032874;
      y = 0;
      flip = 0;
      while (z > pi) z -= 2 * pi;
      while (z < -pi) z += 2 * pi;
      if (z > 64'sd1686629713) begin
        z -= pi;
        flip = 1;
      end else if (z < -64'sd1686629713) begin
        z += pi;
        flip = 1;
      end
      for (int i = 0; i < ITERS; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(ATAN_STEPS[i]);
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(ATAN_STEPS[i]);
        end
        x = t;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
    endfunction

    function void note_item(xform_t it);
      longint s1, c1, s2, c2, s3, c3, s1s2, c1s2, m, q;
      longint rot [3][3];
      longint fac [3];
      bit zero;
      column_t col;
      zero = 0;
      sincos(it.ay, s1, c1);
      sincos(it.ax, s2, c2);
      sincos(it.az, s3, c3);
      s1s2 = rnd30(s1, s2);
      c1s2 = rnd30(c1, s2);
      rot[0][0] = rnd30(c1, c3) + rnd30(s1s2, s3);
      rot[0][1] = rnd30(c2, s3);
      rot[0][2] = rnd30(c1s2, s3) - rnd30(s1, c3);
      rot[1][0] = rnd30(s1s2, c3) - rnd30(s3, c1);
      rot[1][1] = rnd30(c2, c3);
      rot[1][2] = rnd30(s1, s3) + rnd30(c1s2, c3);
      rot[2][0] = rnd30(s1, c2);
      rot[2][1] = -s2;
      rot[2][2] = rnd30(c1, c2);
      for (int j = 0; j < 3; j++) begin
        if (it.op == OP_NORMAL) begin
          if (it.sc[j] == 0) begin
            zero = 1;
            fac[j] = 64'sd2147483647;
          end else begin
            m = it.sc[j] < 0 ? -longint'(it.sc[j]) : longint'(it.sc[j]);
            q = ((64'sd1 <<< (2 * FRAC)) + m / 2) / m;
            fac[j] = clamp(it.sc[j] < 0 ? -q : q);
          end
        end else fac[j] = it.sc[j];
      end
      for (int j = 0; j < 4; j++) begin
        col.idx = 2'(j);
        for (int r = 0; r < 3; r++)
          col.e[r] = j < 3 ? 32'(clamp(rnd30(rot[j][r], fac[j])))
                           : (it.op == OP_NORMAL ? 32'sd0 : it.ps[r]);
        col.e[3] = j < 3 ? 32'sd0 : 32'sd1 <<< FRAC;
        col.zs = zero;
        col.last = j == 3;
        pending.push_back(col);
      end
    endfunction

    function void check_word(column_t got);
      column_t w;
      if (pending.size() == 0) begin
        $error("column word with none expected");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.idx !== w.idx) begin
        $error("column_index expected %0d got %0d", w.idx, got.idx);
        errors++;
      end
      for (int r = 0; r < 4; r++)
        if (got.e[r] !== w.e[r]) begin
          $error("elem_row%0d expected %0d got %0d", r, w.e[r], got.e[r]);
          errors++;
        end
      if (got.zs !== w.zs) begin
        $error("zero_scale expected %0b got %0b", w.zs, got.zs);
        errors++;
      end
      if (got.last !== w.last) begin
        $error("last_column expected %0b got %0b", w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_operation = 0;
  logic signed [17:0] in_angle_x = 0, in_angle_y = 0, in_angle_z = 0;
  logic signed [31:0] in_scale_x = 0, in_scale_y = 0, in_scale_z = 0;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_column_index;
  logic signed [31:0] out_elem_row0, out_elem_row1, out_elem_row2, out_elem_row3;
  logic out_zero_scale, out_last_column;

  column_board board = new();
  bit quiet = 0;

  euler_scale_translate_matrix u_top (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    column_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.idx = out_column_index;
      got.e[0] = out_elem_row0;
      got.e[1] = out_elem_row1;
      got.e[2] = out_elem_row2;
      got.e[3] = out_elem_row3;
      got.zs = out_zero_scale;
      got.last = out_last_column;
      board.check_word(got);
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic xform_t rand_item();
    xform_t it;
    it.op = 1'($urandom_range(0, 1));
    it.ax = 18'($urandom());
    it.ay = 18'($urandom());
    it.az = 18'($urandom());
    for (int j = 0; j < 3; j++) begin
      it.sc[j] = rand_word();
      it.ps[j] = rand_word();
    end
    return it;
  endfunction

  task automatic send_item(xform_t it);
    in_valid <= 1;
    in_operation <= it.op;
    in_angle_x <= it.ax;
    in_angle_y <= it.ay;
    in_angle_z <= it.az;
    in_scale_x <= it.sc[0];
    in_scale_y <= it.sc[1];
    in_scale_z <= it.sc[2];
    in_pos_x <= it.ps[0];
    in_pos_y <= it.ps[1];
    in_pos_z <= it.ps[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    xform_t it;
    logic signed [17:0] angs [6];
    int waited;
    angs = '{18'sh1FFFF, -18'sh20000, 0, 18'sd25736, -18'sd25736, 18'sd51472};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: angle extremes, quarter and half turns, both operations
    for (int k = 0; k < 12; k++) begin
      it.op = k[0] ? OP_NORMAL : OP_MODEL;
      it.ax = angs[k % 6];
      it.ay = angs[(k + 2) % 6];
      it.az = angs[(k + 4) % 6];
      it.sc = '{32'sh10000, -32'sh20000, 32'sh00008000};
      it.ps = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd12345};
      send_item(it);
    end
    // zero scales, unit and tiny scales, word extremes
    it.ax = 18'sd1000; it.ay = -18'sd3000; it.az = 18'sd7000;
    it.op = OP_NORMAL; it.sc = '{0, 32'sh10000, 32'sh10000}; send_item(it);
    it.sc = '{32'sh10000, 0, 0}; send_item(it);
    it.sc = '{1, -1, 32'sh7FFFFFFF}; send_item(it);
    it.sc = '{32'sh80000000, 2, -2}; send_item(it);
    it.op = OP_MODEL; it.sc = '{0, 32'sh7FFFFFFF, 32'sh80000000}; send_item(it);
    it.ps = '{0, -1, 1}; send_item(it);
    it.op = OP_NORMAL; it.sc = '{-32'sh10000, 32'sh3, 32'sh7FFFFFFF}; send_item(it);
    // let everything drain before the random part
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    for (int k = 0; k < 400; k++) begin
      if (k == 340) quiet = 1;
      send_item(rand_item());
      maybe_gap();
    end
    in_valid <= 0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
